FILE: rtl/rotated_matrix_view_store_defines.svh
// ----------------------------------------------------------------------------
// rotated_matrix_view_store_defines
// Assertion macros shared by the checker of the rotated matrix view store.
// ----------------------------------------------------------------------------
`ifndef ROTATED_MATRIX_VIEW_STORE_DEFINES_SVH
`define ROTATED_MATRIX_VIEW_STORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RMVS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define RMVS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rmvs_pkg.sv
// ----------------------------------------------------------------------------
// rmvs_pkg
// Types and constants of the rotated matrix view store.
// ----------------------------------------------------------------------------
package rmvs_pkg;

    localparam int COORD_W = 5;
    localparam int VALUE_W = 16;
    localparam int ANGLE_W = 18;
    localparam int SIZE_W  = 6;
    localparam int TURN_W  = 2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

    // quarter turns = angle / 90 via reciprocal: (a * ceil(2^25/90)) >> 25
    localparam int ANGLE_SHIFT = 25;
    localparam int PROD_W      = 37;
    localparam logic [PROD_W-1:0] ANGLE_RECIP = 37'd372828;

    typedef enum logic [1:0] {
        FN_LOAD   = 2'd0,
        FN_ROTATE = 2'd1,
        FN_QUERY  = 2'd2,
        FN_UPDATE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_READ = 2'd1,
        ST_RESP = 2'd2
    } state_t;

    typedef struct packed {
        logic take_item;
        logic load_result;
    } cmd_t;

    typedef struct packed {
        logic is_query;
    } status_t;

    function automatic logic [TURN_W-1:0] quarter_count(input logic [ANGLE_W-1:0] angle);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(angle) * ANGLE_RECIP;
        return prod[ANGLE_SHIFT+TURN_W-1:ANGLE_SHIFT];
    endfunction

endpackage

FILE: rtl/rmvs_ram.sv
// ----------------------------------------------------------------------------
// rmvs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rmvs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AddrW-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/rmvs_ctrl.sv
// ----------------------------------------------------------------------------
// rmvs_ctrl
// Request sequencer: accepts requests, steps queries through the RAM read
// and holds the response until it is taken.
// ----------------------------------------------------------------------------
module rmvs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  rmvs_pkg::status_t status,
    output rmvs_pkg::cmd_t    cmd
);

    rmvs_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rmvs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        s_ready         = 1'b0;
        m_valid         = 1'b0;
        cmd.take_item   = 1'b0;
        cmd.load_result = 1'b0;
        unique case (state_reg)
            rmvs_pkg::ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.take_item = s_valid;
                if (s_valid && status.is_query) begin
                    state_next = rmvs_pkg::ST_READ;
                end
            end
            rmvs_pkg::ST_READ: begin
                cmd.load_result = 1'b1;
                state_next      = rmvs_pkg::ST_RESP;
            end
            rmvs_pkg::ST_RESP: begin
                m_valid       = 1'b1;
                s_ready       = m_ready;
                cmd.take_item = s_valid && m_ready;
                if (m_ready) begin
                    state_next = (s_valid && status.is_query) ? rmvs_pkg::ST_READ
                                                              : rmvs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rmvs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/rmvs_datapath.sv
// ----------------------------------------------------------------------------
// rmvs_datapath
// Size and turn registers, view-to-original coordinate remap, element RAM
// and response register.
// ----------------------------------------------------------------------------
module rmvs_datapath #(
    parameter int MAX_DIM = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  rmvs_pkg::cmd_t                 cmd,
    output rmvs_pkg::status_t              status,
    input  logic [1:0]                     s_func,
    input  logic [rmvs_pkg::COORD_W-1:0]   s_row_index,
    input  logic [rmvs_pkg::COORD_W-1:0]   s_col_index,
    input  logic [rmvs_pkg::VALUE_W-1:0]   s_elem_value,
    input  logic [rmvs_pkg::ANGLE_W-1:0]   s_angle_deg,
    input  logic                           cfg_write,
    input  logic [rmvs_pkg::SIZE_W-1:0]    cfg_matrix_size,
    output logic [rmvs_pkg::VALUE_W-1:0]   m_read_value
);

    localparam int Depth = MAX_DIM * MAX_DIM;
    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

    logic [rmvs_pkg::SIZE_W-1:0]  size_reg;
    logic [rmvs_pkg::TURN_W-1:0]  turns_reg;
    logic                         in_range_reg;
    logic [rmvs_pkg::VALUE_W-1:0] result_reg;

    rmvs_pkg::func_t              func;
    logic [rmvs_pkg::SIZE_W-1:0]  size_n;
    logic [rmvs_pkg::SIZE_W-1:0]  last_n;
    logic [rmvs_pkg::SIZE_W-1:0]  row_w;
    logic [rmvs_pkg::SIZE_W-1:0]  col_w;
    logic [rmvs_pkg::SIZE_W-1:0]  orow;
    logic [rmvs_pkg::SIZE_W-1:0]  ocol;
    logic [rmvs_pkg::TURN_W-1:0]  map_turns;
    logic                         in_range;
    logic [AddrW-1:0]             addr;
    logic                         wr_en;
    logic                         rd_en;
    logic [rmvs_pkg::VALUE_W-1:0] rd_data;

    assign func            = rmvs_pkg::func_t'(s_func);
    assign status.is_query = (func == rmvs_pkg::FN_QUERY);

    always_comb begin
        if (size_reg == '0) begin
            size_n = rmvs_pkg::SIZE_W'(1);
        end else if (32'(size_reg) > 32'(MAX_DIM)) begin
            size_n = rmvs_pkg::SIZE_W'(MAX_DIM);
        end else begin
            size_n = size_reg;
        end
    end

    assign last_n    = size_n - rmvs_pkg::SIZE_W'(1);
    assign row_w     = rmvs_pkg::SIZE_W'(s_row_index);
    assign col_w     = rmvs_pkg::SIZE_W'(s_col_index);
    assign in_range  = (row_w < size_n) && (col_w < size_n);
    assign map_turns = status.is_query ? turns_reg : '0;

    // view (r,c) -> original coordinates
    always_comb begin
        case (map_turns)
            2'd1: begin
                orow = last_n - col_w;
                ocol = row_w;
            end
            2'd2: begin
                orow = last_n - row_w;
                ocol = last_n - col_w;
            end
            2'd3: begin
                orow = col_w;
                ocol = last_n - row_w;
            end
            default: begin
                orow = row_w;
                ocol = col_w;
            end
        endcase
    end

    assign addr  = AddrW'(32'(orow) * 32'(MAX_DIM) + 32'(ocol));
    assign wr_en = cmd.take_item && in_range &&
                   ((func == rmvs_pkg::FN_LOAD) || (func == rmvs_pkg::FN_UPDATE));
    assign rd_en = cmd.take_item && status.is_query;

    rmvs_ram #(
        .WIDTH (rmvs_pkg::VALUE_W),
        .DEPTH (Depth)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (addr),
        .wr_data (s_elem_value),
        .rd_en   (rd_en),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg  <= rmvs_pkg::SIZE_RESET;
            turns_reg <= '0;
        end else begin
            if (cfg_write) begin
                size_reg <= cfg_matrix_size;
            end
            if (cmd.take_item && (func == rmvs_pkg::FN_ROTATE)) begin
                turns_reg <= turns_reg + rmvs_pkg::quarter_count(s_angle_deg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            in_range_reg <= in_range;
        end
        if (cmd.load_result) begin
            result_reg <= in_range_reg ? rd_data : '0;
        end
    end

    assign m_read_value = result_reg;

endmodule

FILE: rtl/rotated_matrix_view_store.sv
// ----------------------------------------------------------------------------
// rotated_matrix_view_store
// Square matrix kept in original orientation with a clockwise quarter-turn
// count; queries remap view coordinates onto the stored matrix.
// Load, update and rotate are taken back to back while no query is in flight.
// Query: response valid after the RAM read and response registers load in
// turn; next request taken in the cycle the response is taken.
// Reset (aresetn low, synchronous): size 32, zero turns, no response pending;
// element RAM contents are not cleared.
// ----------------------------------------------------------------------------
module rotated_matrix_view_store #(
    parameter int MAX_DIM = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_func,
    input  logic [rmvs_pkg::COORD_W-1:0] s_row_index,
    input  logic [rmvs_pkg::COORD_W-1:0] s_col_index,
    input  logic [rmvs_pkg::VALUE_W-1:0] s_elem_value,
    input  logic [rmvs_pkg::ANGLE_W-1:0] s_angle_deg,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [rmvs_pkg::VALUE_W-1:0] m_read_value,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rmvs_pkg::SIZE_W-1:0]  cfg_matrix_size
);

    rmvs_pkg::cmd_t    cmd;
    rmvs_pkg::status_t status;

    assign cfg_ready = 1'b1;

    rmvs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rmvs_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_func          (s_func),
        .s_row_index     (s_row_index),
        .s_col_index     (s_col_index),
        .s_elem_value    (s_elem_value),
        .s_angle_deg     (s_angle_deg),
        .cfg_write       (cfg_valid && cfg_ready),
        .cfg_matrix_size (cfg_matrix_size),
        .m_read_value    (m_read_value)
    );

endmodule

FILE: rtl/rmvs_checker.sv
// ----------------------------------------------------------------------------
// rmvs_checker
// Port-level checks of request and response timing.
// ----------------------------------------------------------------------------
`include "rotated_matrix_view_store_defines.svh"

module rmvs_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic [1:0]                   s_func,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [rmvs_pkg::VALUE_W-1:0] m_read_value
);

    logic s_take;
    logic s_take_query;

    assign s_take       = s_valid && s_ready;
    assign s_take_query = s_take && (s_func == rmvs_pkg::FN_QUERY);

    `RMVS_ASSERT_NEXT(a_query_resp, aclk, aresetn, s_take_query, !m_valid ##1 m_valid, "query response not valid two cycles after request")
    `RMVS_ASSERT_NEXT(a_no_spurious_resp, aclk, aresetn, s_take && !s_take_query, !m_valid, "response after non-query request")
    `RMVS_ASSERT_NOW(a_stall_blocks_req, aclk, aresetn, m_valid && !m_ready, !s_ready, "request taken while response stalled")
    `RMVS_ASSERT_NEXT(a_resp_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_read_value), "stalled response dropped or changed")

endmodule

bind rotated_matrix_view_store rmvs_checker u_rmvs_checker (.*);

FILE: sim/rotated_matrix_view_store_tb.sv
// ----------------------------------------------------------------------------
// rotated_matrix_view_store_tb
// Self-checking bench for the rotated matrix view store. A directed table
// covers corners, every operation, angle truncation, odd sizes and
// out-of-range coordinates. Random phases follow at several matrix sizes and
// back-pressure mixes. Every query response is checked against a pinned
// answer or an in-bench model of the matrix and its quarter-turn count.
// ----------------------------------------------------------------------------
module rotated_matrix_view_store_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rmvs_pkg::*;

    localparam int DIM        = 32;
    localparam int STALL_MAX  = 2000;
    localparam int DRAIN_WAIT = 4;
    localparam int PHASE_REQS = 106;
    localparam int NPHASES    = 8;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        func_t             func;
        logic [COORD_W-1:0] r;
        logic [COORD_W-1:0] c;
        logic [VALUE_W-1:0] v;
        logic [ANGLE_W-1:0] ang;
        bit                pinned;
        logic [VALUE_W-1:0] want;
    } row_t;

    logic               aclk;
    logic               aresetn         = 1'b0;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic [1:0]         s_func          = FN_LOAD;
    logic [COORD_W-1:0] s_row_index     = '0;
    logic [COORD_W-1:0] s_col_index     = '0;
    logic [VALUE_W-1:0] s_elem_value    = '0;
    logic [ANGLE_W-1:0] s_angle_deg     = '0;
    logic               m_valid;
    logic               m_ready         = 1'b1;
    logic [VALUE_W-1:0] m_read_value;
    logic               cfg_valid       = 1'b0;
    logic               cfg_ready;
    logic [SIZE_W-1:0]  cfg_matrix_size = SIZE_RESET;

    // pinned answer travels with the request it belongs to
    bit                 pin_on          = 1'b0;
    logic [VALUE_W-1:0] pin_val         = '0;

    logic [VALUE_W-1:0] elem_mem [DIM*DIM];
    bit                 elem_written [DIM*DIM];
    logic [TURN_W-1:0]  turns     = '0;
    logic [SIZE_W-1:0]  size_reg  = SIZE_RESET;
    logic [VALUE_W-1:0] read_q [$];

    int                 err_count     = 0;
    int                 quiet_cycles  = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;

    func_t              mon_func;
    int                 mon_n;
    logic [9:0]         mon_addr;
    logic [VALUE_W-1:0] mon_want;
    logic [VALUE_W-1:0] got_want;

    row_t dir_rows [25] = '{
        '{ROW_REQ, FN_LOAD,   5'd0,  5'd0,  16'hFFFF, 18'd0,      1'b0, 16'h0000},
        '{ROW_REQ, FN_LOAD,   5'd0,  5'd31, 16'hA5A5, 18'd0,      1'b0, 16'h0000},
        '{ROW_REQ, FN_LOAD,   5'd31, 5'd0,  16'h5A5A, 18'd0,      1'b0, 16'h0000},
        '{ROW_REQ, FN_LOAD,   5'd31, 5'd31, 16'h0000, 18'd0,      1'b0, 16'h0000},
        '{ROW_REQ, FN_QUERY,  5'd0,  5'd0,  16'h0000, 18'd0,      1'b1, 16'hFFFF},
        '{ROW_REQ, FN_QUERY,  5'd31, 5'd31, 16'h0000, 18'd0,      1'b1, 16'h0000},
        '{ROW_REQ, FN_ROTATE, 5'd0,  5'd0,  16'h0000, 18'd90,     1'b0, 16'h0000},
        '{ROW_REQ, FN_QUERY,  5'd0,  5'd0,  16'h0000, 18'd0,      1'b1, 16'h5A5A},
        '{ROW_REQ, FN_ROTATE, 5'd0,  5'd0,  16'h0000, 18'd89,     1'b0, 16'h0000},
        '{ROW_REQ, FN_QUERY,  5'd0,  5'd31, 16'h0000, 18'd0,      1'b1, 16'hFFFF},
        '{ROW_REQ, FN_ROTATE, 5'd0,  5'd0,  16'h0000, 18'd262143, 1'b0, 16'h0000},
        '{ROW_REQ, FN_ROTATE, 5'd0,  5'd0,  16'h0000, 18'd180,    1'b0, 16'h0000},
        '{ROW_REQ, FN_QUERY,  5'd0,  5'd0,  16'h0000, 18'd0,      1'b1, 16'hA5A5},
        '{ROW_REQ, FN_UPDATE, 5'd0,  5'd31, 16'h1234, 18'd0,      1'b0, 16'h0000},
        '{ROW_REQ, FN_QUERY,  5'd0,  5'd0,  16'h0000, 18'd0,      1'b1, 16'h1234},
        '{ROW_REQ, FN_ROTATE, 5'd0,  5'd0,  16'h0000, 18'd270,    1'b0, 16'h0000},
        '{ROW_REQ, FN_QUERY,  5'd0,  5'd0,  16'h0000, 18'd0,      1'b1, 16'h0000},
        '{ROW_REQ, FN_ROTATE, 5'd0,  5'd0,  16'h0000, 18'd360,    1'b0, 16'h0000},
        '{ROW_CFG, FN_LOAD,   5'd0,  5'd0,  16'd0,    18'd0,      1'b0, 16'h0000},
        '{ROW_REQ, FN_QUERY,  5'd0,  5'd0,  16'h0000, 18'd0,      1'b1, 16'hFFFF},
        '{ROW_REQ, FN_QUERY,  5'd1,  5'd0,  16'h0000, 18'd0,      1'b1, 16'h0000},
        '{ROW_REQ, FN_LOAD,   5'd1,  5'd1,  16'hBEEF, 18'd0,      1'b0, 16'h0000},
        '{ROW_REQ, FN_QUERY,  5'd1,  5'd1,  16'h0000, 18'd0,      1'b1, 16'h0000},
        '{ROW_CFG, FN_LOAD,   5'd0,  5'd0,  16'd63,   18'd0,      1'b0, 16'h0000},
        '{ROW_REQ, FN_QUERY,  5'd31, 5'd31, 16'h0000, 18'd0,      1'b1, 16'hFFFF}
    };

    logic [SIZE_W-1:0] phase_sizes [NPHASES] = '{
        6'd32, 6'd1, 6'd0, 6'd63, 6'd4, 6'd17, 6'd31, 6'd33
    };

    rotated_matrix_view_store #(
        .MAX_DIM(DIM)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_row_index     (s_row_index),
        .s_col_index     (s_col_index),
        .s_elem_value    (s_elem_value),
        .s_angle_deg     (s_angle_deg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_value    (m_read_value),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_matrix_size (cfg_matrix_size)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int side_len(input logic [SIZE_W-1:0] sz);
        if (sz == 0) return 1;
        if (sz > DIM) return DIM;
        return int'(sz);
    endfunction

    // view (r,c) -> address of the stored element in original orientation
    function automatic logic [9:0] view_addr(input logic [COORD_W-1:0] r,
                                             input logic [COORD_W-1:0] c,
                                             input int n,
                                             input logic [TURN_W-1:0] qt);
        int orow;
        int ocol;
        case (qt)
            2'd0: begin orow = r;         ocol = c;         end
            2'd1: begin orow = n - 1 - c; ocol = r;         end
            2'd2: begin orow = n - 1 - r; ocol = n - 1 - c; end
            default: begin orow = c;      ocol = n - 1 - r; end
        endcase
        return 10'(orow * DIM + ocol);
    endfunction

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (read_q.size() == 0) begin
                    $error("unexpected response read_value=%h", m_read_value);
                    err_count++;
                end else begin
                    got_want = read_q.pop_front();
                    if (m_read_value !== got_want) begin
                        $error("read_value expected %h actual %h", got_want, m_read_value);
                        err_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                size_reg = cfg_matrix_size;
            if (s_valid && s_ready) begin
                mon_func = func_t'(s_func);
                mon_n    = side_len(size_reg);
                case (mon_func)
                    FN_ROTATE: turns = turns + TURN_W'((s_angle_deg / 90) % 4);
                    FN_QUERY: begin
                        mon_want = '0;
                        if (s_row_index < mon_n && s_col_index < mon_n) begin
                            mon_addr = view_addr(s_row_index, s_col_index, mon_n, turns);
                            mon_want = elem_mem[mon_addr];
                        end
                        read_q.push_back(pin_on ? pin_val : mon_want);
                    end
                    default: begin
                        if (s_row_index < mon_n && s_col_index < mon_n) begin
                            mon_addr = 10'(s_row_index * DIM + s_col_index);
                            elem_mem[mon_addr]     = s_elem_value;
                            elem_written[mon_addr] = 1'b1;
                        end
                    end
                endcase
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_MAX) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_req(input func_t f, input logic [COORD_W-1:0] r,
                            input logic [COORD_W-1:0] c, input logic [VALUE_W-1:0] v,
                            input logic [ANGLE_W-1:0] ang, input bit pinned,
                            input logic [VALUE_W-1:0] want);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= f;
        s_row_index  <= r;
        s_col_index  <= c;
        s_elem_value <= v;
        s_angle_deg  <= ang;
        pin_on       <= pinned;
        pin_val      <= want;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] sz);
        s_valid <= 1'b0;
        while (read_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
        cfg_valid       <= 1'b1;
        cfg_matrix_size <= sz;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random();
        int                 n;
        int                 roll;
        func_t              f;
        logic [COORD_W-1:0] r;
        logic [COORD_W-1:0] c;
        logic [ANGLE_W-1:0] ang;
        logic [9:0]         a;
        n    = side_len(size_reg);
        roll = $urandom_range(0, 99);
        if (roll < 30)      f = FN_LOAD;
        else if (roll < 45) f = FN_UPDATE;
        else if (roll < 60) f = FN_ROTATE;
        else                f = FN_QUERY;
        if ($urandom_range(0, 99) < 15) begin
            r = COORD_W'($urandom);
            c = COORD_W'($urandom);
        end else begin
            r = COORD_W'($urandom_range(0, n - 1));
            c = COORD_W'($urandom_range(0, n - 1));
        end
        if ($urandom_range(0, 1) != 0)
            ang = ANGLE_W'($urandom_range(0, 2912) * 90);
        else
            ang = ANGLE_W'($urandom);
        // never read an entry that was not written: write it instead
        if (f == FN_QUERY && r < n && c < n) begin
            a = view_addr(r, c, n, turns);
            if (!elem_written[a]) begin
                f = FN_LOAD;
                r = a[9:5];
                c = a[4:0];
            end
        end
        send_req(f, r, c, VALUE_W'($urandom), ang, 1'b0, '0);
    endtask

    initial begin
        foreach (elem_mem[i]) begin
            elem_mem[i]     = '0;
            elem_written[i] = 1'b0;
        end
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG)
                write_size(SIZE_W'(dir_rows[i].v));
            else
                send_req(dir_rows[i].func, dir_rows[i].r, dir_rows[i].c, dir_rows[i].v,
                         dir_rows[i].ang, dir_rows[i].pinned, dir_rows[i].want);
        end

        for (int p = 0; p < NPHASES; p++) begin
            write_size(phase_sizes[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            repeat (PHASE_REQS) send_random();
        end

        s_valid <= 1'b0;
        while (read_q.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
